[src/stable_min_priority_queue_assert.svh]
// assertion macros shared by the priority queue rtl
`ifndef STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define SMPQ_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("smpq assertion failed");

// consequent holds in the same cycle as the antecedent
`define SMPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smpq assertion failed");

// consequent holds in the cycle after the antecedent
`define SMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smpq assertion failed");

`endif

[src/smpq_pkg.sv]
// shared codes for the stable min priority queue
package smpq_pkg;

	// operation field codes
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

endpackage

[src/stable_min_priority_queue.sv]
// stable min priority queue: sorted ring of entries in one ram
//
//   channel | direction | payload                                          | handshake
//   in      | input     | operation, elem, priority_req                    | in_valid/in_ready
//   out     | output    | front_elem, front_priority, count, empty_res,    | out_valid/out_ready
//           |           | status                                           |
//
// a dequeue, a dropped enqueue or an enqueue into an empty queue runs S_READF, S_RESP.
// an enqueue into a non-empty queue runs S_SHIFT, which walks back from the tail past
// the stored entries with greater priority, moving one entry per cycle through the
// single ram read and write port, then S_INS if all moved, then S_READF and S_RESP.
// arst_n clears count, ring pointers and handshake state; the ram is not cleared.
// a result waiting on out_ready does not stop the next transaction from being taken,
// only its own completion waits for the output register.
`include "stable_min_priority_queue_assert.svh"

module stable_min_priority_queue #(
	parameter int DEPTH = 16,
	parameter int ELEM_WIDTH = 32,
	parameter int PRIORITY_WIDTH = 16,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      operation,
	input  logic [ELEM_WIDTH-1:0]     elem,
	input  logic [PRIORITY_WIDTH-1:0] priority_req,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ELEM_WIDTH-1:0]     front_elem,
	output logic [PRIORITY_WIDTH-1:0] front_priority,
	output logic [CW-1:0]             count,
	output logic                      empty_res,
	output logic [1:0]                status
);

	localparam int DW = ELEM_WIDTH + PRIORITY_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_INS,
		S_READF,
		S_RESP
	} state_t;

	state_t                    state_q;
	logic [AW-1:0]             head_q;
	logic [AW-1:0]             tail_q;
	logic [CW-1:0]             count_q;
	logic [AW-1:0]             idx_q;
	logic [CW-1:0]             rem_q;
	logic [ELEM_WIDTH-1:0]     new_elem_q;
	logic [PRIORITY_WIDTH-1:0] new_prio_q;
	smpq_pkg::status_t         status_q;

	logic                      out_valid_q;
	logic [ELEM_WIDTH-1:0]     front_elem_q;
	logic [PRIORITY_WIDTH-1:0] front_prio_q;
	logic [CW-1:0]             out_count_q;
	logic                      empty_q;
	smpq_pkg::status_t         out_status_q;

	logic                      in_fire;
	logic                      out_free;
	logic                      is_full;
	logic                      is_empty;
	logic                      deq_on_empty;
	logic                      enq_on_full;
	logic [AW-1:0]             idx_m1;
	logic [AW-1:0]             idx_m2;
	logic [AW-1:0]             tail_m1;

	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic [DW-1:0]             wr_data;
	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	logic [DW-1:0]             rd_data;
	logic [ELEM_WIDTH-1:0]     rd_elem;
	logic [PRIORITY_WIDTH-1:0] rd_prio;
	logic                      rd_greater;

	// ring pointer steps
	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
	endfunction

	assign in_ready     = (state_q == S_IDLE);
	assign in_fire      = in_valid && in_ready;
	assign out_free     = !out_valid_q || out_ready;
	assign is_full      = (count_q == CW'(DEPTH));
	assign is_empty     = (count_q == '0);
	assign deq_on_empty = in_fire && operation == smpq_pkg::OP_DEQ && is_empty;
	assign enq_on_full  = in_fire && operation == smpq_pkg::OP_ENQ && is_full;
	assign idx_m1       = ring_dec(idx_q);
	assign idx_m2       = ring_dec(idx_m1);
	assign tail_m1      = ring_dec(tail_q);
	assign rd_elem      = rd_data[ELEM_WIDTH-1:0];
	assign rd_prio      = rd_data[DW-1:ELEM_WIDTH];
	assign rd_greater   = (rd_prio > new_prio_q);

	// ram access per state
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = {new_prio_q, new_elem_q};
		rd_en   = 1'b0;
		rd_addr = head_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && operation == smpq_pkg::OP_ENQ && !is_full) begin
					if (is_empty) begin
						wr_en   = 1'b1;
						wr_addr = tail_q;
						wr_data = {priority_req, elem};
					end else begin
						rd_en   = 1'b1;
						rd_addr = tail_m1;
					end
				end
			end
			S_SHIFT: begin
				wr_en = 1'b1;
				if (rd_greater) begin
					wr_data = rd_data;
					if (rem_q != CW'(1)) begin
						rd_en   = 1'b1;
						rd_addr = idx_m2;
					end
				end
			end
			S_INS: begin
				wr_en = 1'b1;
			end
			S_READF: begin
				rd_en = 1'b1;
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	smpq_ram #(
		.DEPTH (DEPTH),
		.WIDTH (DW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// transaction payload capture, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			new_elem_q <= elem;
			new_prio_q <= priority_req;
		end
	end

	// sequencer with ring pointers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			rem_q        <= '0;
			status_q     <= smpq_pkg::STAT_OK;
			out_valid_q  <= 1'b0;
			front_elem_q <= '0;
			front_prio_q <= '0;
			out_count_q  <= '0;
			empty_q      <= 1'b1;
			out_status_q <= smpq_pkg::STAT_OK;
		end else begin
			// result taken, unless a new one replaces it in this cycle
			if (out_valid_q && out_ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						status_q <= smpq_pkg::STAT_OK;
						state_q  <= S_READF;
						if (operation == smpq_pkg::OP_ENQ) begin
							if (is_full) begin
								status_q <= smpq_pkg::STAT_FULL;
							end else begin
								tail_q  <= ring_inc(tail_q);
								count_q <= count_q + CW'(1);
								if (!is_empty) begin
									idx_q   <= tail_q;
									rem_q   <= count_q;
									state_q <= S_SHIFT;
								end
							end
						end else begin
							if (is_empty) begin
								status_q <= smpq_pkg::STAT_EMPTY;
							end else begin
								head_q  <= ring_inc(head_q);
								count_q <= count_q - CW'(1);
							end
						end
					end
				end
				S_SHIFT: begin
					// move a larger entry up one slot, or drop the new one in here
					if (rd_greater) begin
						idx_q <= idx_m1;
						rem_q <= rem_q - CW'(1);
						if (rem_q == CW'(1)) begin
							state_q <= S_INS;
						end
					end else begin
						state_q <= S_READF;
					end
				end
				S_INS: begin
					state_q <= S_READF;
				end
				S_READF: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						front_elem_q <= is_empty ? '0 : rd_elem;
						front_prio_q <= is_empty ? '0 : rd_prio;
						out_count_q  <= count_q;
						empty_q      <= is_empty;
						out_status_q <= status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign front_elem     = front_elem_q;
	assign front_priority = front_prio_q;
	assign count          = out_count_q;
	assign empty_res      = empty_q;
	assign status         = out_status_q;

	// checks on the ring and the insertion walk
	`SMPQ_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH))
	`SMPQ_ASSERT_IMPL(a_empty_ring, clk, arst_n, count_q == '0, head_q == tail_q)
	`SMPQ_ASSERT_IMPL(a_shift_rem, clk, arst_n, state_q == S_SHIFT, rem_q != '0)
	`SMPQ_ASSERT_NEXT(a_deq_empty_hold, clk, arst_n, deq_on_empty, is_empty && head_q == $past(head_q))
	`SMPQ_ASSERT_NEXT(a_full_hold, clk, arst_n, enq_on_full, is_full && tail_q == $past(tail_q))

endmodule

[src/smpq_ram.sv]
// entry store: one write port, one registered read port
module smpq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 48,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data registered and valid in the cycle after rd_en
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sim/stable_min_priority_queue_tb.sv]
// testbench for the stable min priority queue: directed and random traffic checked by a sorted-list predictor
module stable_min_priority_queue_tb;

	localparam int QDEPTH = 16;
	localparam int EW = 32;
	localparam int PW = 16;
	localparam int CNTW = $clog2(QDEPTH + 1);
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 60;

	// one pending transaction for the driver, or a pause marker
	typedef struct {
		logic          op;
		logic [EW-1:0] elem;
		logic [PW-1:0] prio;
		int unsigned   send_idle;
		int unsigned   recv_idle;
		int unsigned   hold;
		bit            pause;
	} queue_op_t;

	// front of the queue as reported after one transaction
	typedef struct {
		logic [EW-1:0]       front_elem;
		logic [PW-1:0]       front_priority;
		logic [CNTW-1:0]     count;
		logic                empty_res;
		smpq_pkg::status_t   status;
	} front_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = smpq_pkg::OP_ENQ;
	logic [EW-1:0] elem = '0;
	logic [PW-1:0] priority_req = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [EW-1:0] front_elem;
	logic [PW-1:0] front_priority;
	logic [CNTW-1:0] count;
	logic empty_res;
	logic [1:0] status;

	queue_op_t op_pend_q[$];
	front_t front_expect_q[$];

	// predictor state: sorted entries, smallest priority first
	logic [PW-1:0] prio_mem[QDEPTH];
	logic [EW-1:0] elem_mem[QDEPTH];
	int stored = 0;

	// traffic knobs shared between driver and receiver
	int unsigned recv_idle = 0;
	int unsigned hold_len = 0;
	int unsigned hold_seq = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	bit in_took = 1'b0;

	// generator knobs
	int unsigned gen_send_idle = 0;
	int unsigned gen_recv_idle = 0;
	int unsigned gen_hold = 0;

	// run statistics
	int err_cnt = 0;
	int n_enq = 0;
	int n_deq = 0;
	int n_full = 0;
	int n_empty = 0;
	int n_checked = 0;
	int max_fill = 0;

	stable_min_priority_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.elem(elem),
		.priority_req(priority_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.front_elem(front_elem),
		.front_priority(front_priority),
		.count(count),
		.empty_res(empty_res),
		.status(status)
	);

	// clock, period 8
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// apply one transaction to the sorted list and return the new front
	function automatic front_t sorted_queue_step(logic op, logic [EW-1:0] e, logic [PW-1:0] p);
		front_t r;
		int pos;
		r.status = smpq_pkg::STAT_OK;
		if (op == smpq_pkg::OP_ENQ) begin
			if (stored >= QDEPTH) begin
				r.status = smpq_pkg::STAT_FULL;
			end else begin
				pos = 0;
				// equal priorities stay in arrival order
				while (pos < stored && prio_mem[pos] <= p)
					pos++;
				for (int k = stored; k > pos; k--) begin
					prio_mem[k] = prio_mem[k-1];
					elem_mem[k] = elem_mem[k-1];
				end
				prio_mem[pos] = p;
				elem_mem[pos] = e;
				stored++;
			end
		end else begin
			if (stored == 0) begin
				r.status = smpq_pkg::STAT_EMPTY;
			end else begin
				for (int k = 1; k < stored; k++) begin
					prio_mem[k-1] = prio_mem[k];
					elem_mem[k-1] = elem_mem[k];
				end
				stored--;
			end
		end
		r.front_elem = (stored > 0) ? elem_mem[0] : '0;
		r.front_priority = (stored > 0) ? prio_mem[0] : '0;
		r.empty_res = (stored == 0);
		r.count = CNTW'(stored);
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [EW-1:0] want,
			input logic [EW-1:0] got);
		$display("mismatch at %0t on %s: expected %0h, got %0h", $realtime, field, want, got);
		err_cnt++;
	endtask

	task automatic add_op(input logic op, input logic [EW-1:0] e, input logic [PW-1:0] p);
		queue_op_t t;
		t.op = op;
		t.elem = e;
		t.prio = p;
		t.send_idle = gen_send_idle;
		t.recv_idle = gen_recv_idle;
		t.hold = gen_hold;
		t.pause = 1'b0;
		gen_hold = 0;
		op_pend_q.push_back(t);
	endtask

	// sender waits here until every outstanding result has come back
	task automatic add_pause();
		queue_op_t t;
		t = '{op: smpq_pkg::OP_ENQ, elem: '0, prio: '0, send_idle: 0,
			recv_idle: gen_recv_idle, hold: 0, pause: 1'b1};
		op_pend_q.push_back(t);
	endtask

	function automatic logic [PW-1:0] pick_prio();
		int unsigned r;
		r = $urandom_range(7);
		if (r < 4)
			return PW'($urandom_range(3));
		else if (r < 6)
			return PW'($urandom_range(16'hFFFF));
		else if (r == 6)
			return '0;
		else
			return '1;
	endfunction

	// driver: input side, changes at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (op_pend_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (op_pend_q[0].pause) begin
				in_valid <= 1'b0;
				if (front_expect_q.size() == 0)
					void'(op_pend_q.pop_front());
			end else if ($urandom_range(99) < op_pend_q[0].send_idle) begin
				in_valid <= 1'b0;
			end else begin
				queue_op_t t;
				t = op_pend_q.pop_front();
				in_valid <= 1'b1;
				operation <= t.op;
				elem <= t.elem;
				priority_req <= t.prio;
				recv_idle <= t.recv_idle;
				if (t.hold > 0) begin
					hold_len <= t.hold;
					hold_seq <= hold_seq + 1;
				end
			end
		end
	end

	// receiver: random stalls plus a long hold-off when requested
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = hold_len;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// monitor: check results and predict accepted transactions at the rising edge
	always @(posedge clk) begin
		front_t want;
		front_t fresh;
		if (!arst_n) begin
			in_took = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (front_expect_q.size() == 0) begin
					report_mismatch("unexpected result", '0, {31'b0, out_valid});
				end else begin
					want = front_expect_q.pop_front();
					n_checked++;
					if (front_elem !== want.front_elem)
						report_mismatch("front_elem", want.front_elem, front_elem);
					if (front_priority !== want.front_priority)
						report_mismatch("front_priority", EW'(want.front_priority),
							EW'(front_priority));
					if (count !== want.count)
						report_mismatch("count", EW'(want.count), EW'(count));
					if (empty_res !== want.empty_res)
						report_mismatch("empty_res", EW'(want.empty_res), EW'(empty_res));
					if (status !== want.status)
						report_mismatch("status", EW'(want.status), EW'(status));
				end
			end
			in_took = in_valid && in_ready;
			if (in_took) begin
				fresh = sorted_queue_step(operation, elem, priority_req);
				front_expect_q.push_back(fresh);
				if (operation == smpq_pkg::OP_ENQ) n_enq++;
				else n_deq++;
				if (fresh.status == smpq_pkg::STAT_FULL) n_full++;
				if (fresh.status == smpq_pkg::STAT_EMPTY) n_empty++;
				if (stored > max_fill) max_fill = stored;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int n;
		int len;
		int unsigned burst;
		logic op;
		bit held;

		// directed: empty dequeue, extremes, ties, drain past empty
		gen_send_idle = 0;
		gen_recv_idle = 0;
		add_op(smpq_pkg::OP_DEQ, '1, '1);
		add_op(smpq_pkg::OP_ENQ, '1, '1);
		add_op(smpq_pkg::OP_ENQ, '0, '0);
		add_op(smpq_pkg::OP_ENQ, 32'h0000_0005, 16'd5);
		add_op(smpq_pkg::OP_ENQ, 32'h0000_0006, 16'd5);
		add_op(smpq_pkg::OP_ENQ, 32'hA5A5_5A5A, 16'd5);
		add_op(smpq_pkg::OP_ENQ, 32'h5A5A_A5A5, 16'hFFFF);
		add_op(smpq_pkg::OP_ENQ, 32'h8000_0001, 16'h8000);
		for (int k = 0; k < 8; k++)
			add_op(smpq_pkg::OP_DEQ, $urandom, pick_prio());
		// fill past full with equal priorities, then a dropped enqueue
		for (int k = 0; k < 17; k++)
			add_op(smpq_pkg::OP_ENQ, $urandom, 16'd7);
		add_pause();

		// random bursts in three traffic phases
		held = 1'b0;
		for (int ph = 0; ph < 3; ph++) begin
			gen_send_idle = (ph == 0) ? 32 : (ph == 1) ? 50 : 0;
			gen_recv_idle = (ph == 0) ? 50 : (ph == 1) ? 32 : 0;
			add_pause();
			n = 0;
			while (n < 330) begin
				burst = $urandom_range(9);
				len = $urandom_range(4, 20);
				if (ph == 0 && !held && n > 100) begin
					gen_hold = HOLD_CYCLES;
					held = 1'b1;
				end
				for (int j = 0; j < len; j++) begin
					if (burst < 3)
						op = smpq_pkg::OP_ENQ;
					else if (burst < 5)
						op = smpq_pkg::OP_DEQ;
					else
						op = $urandom_range(1);
					add_op(op, $urandom, pick_prio());
					n++;
				end
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (op_pend_q.size() != 0 || in_valid)
			@(posedge clk);
		while (front_expect_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d enqueues (%0d dropped on full) and %0d dequeues (%0d on empty)",
			n_enq, n_full, n_deq, n_empty);
		$display("%0d results checked, deepest fill %0d entries, %0d mismatches",
			n_checked, max_fill, err_cnt);
		if (err_cnt == 0 && front_expect_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(8 * 400000);
		$display("watchdog expired with %0d results outstanding", front_expect_q.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
